[hw/rtl/uint8_conv_dot_requant_unit_assert.svh]
`ifndef UINT8_CONV_DOT_REQUANT_UNIT_ASSERT_SVH
`define UINT8_CONV_DOT_REQUANT_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define UCDR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define UCDR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/ucdr_pkg.sv]
`default_nettype none

package ucdr_pkg;

	localparam int LANES        = 4;
	localparam int ACC_BITS_DEF = 48;

	localparam int PROD_W = 18;
	localparam int LSUM_W = PROD_W + $clog2(LANES);

	localparam int MAG_W   = 64;
	localparam int HALF_W  = 32;
	localparam int MULT_W  = 31;
	localparam int SHIFT_W = 6;
	localparam int PP_W    = HALF_W + MULT_W;
	localparam int WIDE_W  = 96;
	localparam int CAP_W   = 41;
	localparam logic [CAP_W-1:0] CAP_VAL = CAP_W'(1) << (CAP_W - 1);
	localparam int Q_W     = CAP_W + 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;

	localparam logic [CFG_IDX_W-1:0] REG_IN_ZERO   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WGT_ZERO  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_ZERO  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MULT      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ACT_MODE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RELU6_TOP = 3'd6;

	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_RELU  = 2'd1;
	localparam logic [1:0] ACT_RELU6 = 2'd2;

	localparam logic [7:0] U8_MAX = 8'hFF;

	localparam logic [MULT_W-1:0]  MULT_RST  = 31'h4000_0000;
	localparam logic [SHIFT_W-1:0] SHIFT_RST = 6'd31;

	typedef struct packed {
		logic [7:0]         out_zero;
		logic [MULT_W-1:0]  mult;
		logic [SHIFT_W-1:0] shift;
		logic [1:0]         act_mode;
		logic [7:0]         relu6_top;
	} rq_cfg_t;

endpackage

`default_nettype wire

[hw/rtl/uint8_conv_dot_requant_unit.sv]
// Throughput: items without last are taken one per cycle; after an item marked last
// the input stays closed while the two 32x31 partial products are formed in
// successive cycles and the result is rounded and clamped, and longer while the
// output register still holds an earlier result that has not been transferred.
// Reset: arst_n clears the accumulator, the handshake state and loads the
// register defaults (multiplier 2^30, shift 31, relu6 top 255, others 0).
`default_nettype none

`include "uint8_conv_dot_requant_unit_assert.svh"

module uint8_conv_dot_requant_unit import ucdr_pkg::*; #(
	parameter int ACC_BITS = ACC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [7:0]            act_0,
	input  wire logic [7:0]            act_1,
	input  wire logic [7:0]            act_2,
	input  wire logic [7:0]            act_3,
	input  wire logic [7:0]            wgt_0,
	input  wire logic [7:0]            wgt_1,
	input  wire logic [7:0]            wgt_2,
	input  wire logic [7:0]            wgt_3,
	input  wire logic [LANES-1:0]      lane_live,
	input  wire logic signed [31:0]    bias,
	input  wire logic                  last,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [7:0]                 out_value,
	output logic                       clipped
);

	logic [7:0]               in_zero_q;
	logic [7:0]               wgt_zero_q;
	rq_cfg_t                  rq_cfg_q;
	logic                     busy_q;
	logic                     accept;
	logic [7:0]               act_a [LANES];
	logic [7:0]               wgt_a [LANES];
	logic signed [PROD_W-1:0] prods [LANES];
	logic                     start_s2;
	logic signed [ACC_BITS-1:0] final_s2;
	logic signed [31:0]       bias_s2;
	logic                     done;

	assign act_a[0] = act_0;
	assign act_a[1] = act_1;
	assign act_a[2] = act_2;
	assign act_a[3] = act_3;
	assign wgt_a[0] = wgt_0;
	assign wgt_a[1] = wgt_1;
	assign wgt_a[2] = wgt_2;
	assign wgt_a[3] = wgt_3;

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_zero_q          <= '0;
			wgt_zero_q         <= '0;
			rq_cfg_q.out_zero  <= '0;
			rq_cfg_q.mult      <= MULT_RST;
			rq_cfg_q.shift     <= SHIFT_RST;
			rq_cfg_q.act_mode  <= ACT_NONE;
			rq_cfg_q.relu6_top <= U8_MAX;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_IN_ZERO:   in_zero_q          <= cfg_data[7:0];
				REG_WGT_ZERO:  wgt_zero_q         <= cfg_data[7:0];
				REG_OUT_ZERO:  rq_cfg_q.out_zero  <= cfg_data[7:0];
				REG_MULT:      rq_cfg_q.mult      <= cfg_data[MULT_W-1:0];
				REG_SHIFT:     rq_cfg_q.shift     <= cfg_data[SHIFT_W-1:0];
				REG_ACT_MODE:  rq_cfg_q.act_mode  <= cfg_data[1:0];
				REG_RELU6_TOP: rq_cfg_q.relu6_top <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// The input stays closed from the closing transfer until its result is registered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept && last) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		ucdr_lane u_lane (
			.clk      (clk),
			.en       (accept),
			.act      (act_a[g]),
			.wgt      (wgt_a[g]),
			.live     (lane_live[g]),
			.in_zero  (in_zero_q),
			.wgt_zero (wgt_zero_q),
			.prod_s1  (prods[g])
		);
	end

	ucdr_merge #(
		.ACC_BITS (ACC_BITS)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.last     (last),
		.bias     (bias),
		.prods    (prods),
		.start_s2 (start_s2),
		.final_s2 (final_s2),
		.bias_s2  (bias_s2)
	);

	ucdr_requant #(
		.ACC_BITS (ACC_BITS)
	) u_requant (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start_s2),
		.acc         (final_s2),
		.bias        (bias_s2),
		.cfg         (rq_cfg_q),
		.out_ready   (out_ready),
		.out_valid_q (out_valid),
		.out_value_q (out_value),
		.clipped_q   (clipped),
		.done_q      (done)
	);

	`UCDR_ASSERT_NEXT(a_close_stall, accept && last, !in_ready,
		"input still open after the closing transfer")

endmodule

`default_nettype wire

[hw/rtl/ucdr_lane.sv]
`default_nettype none

module ucdr_lane import ucdr_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic [7:0]               act,
	input  wire logic [7:0]               wgt,
	input  wire logic                     live,
	input  wire logic [7:0]               in_zero,
	input  wire logic [7:0]               wgt_zero,
	output logic signed [PROD_W-1:0]      prod_s1
);

	logic signed [8:0]        a_d;
	logic signed [8:0]        w_d;
	logic signed [PROD_W-1:0] prod;

	assign a_d  = $signed({1'b0, act}) - $signed({1'b0, in_zero});
	assign w_d  = $signed({1'b0, wgt}) - $signed({1'b0, wgt_zero});

	always_comb begin
		prod = '0;
		if (live) begin
			prod = a_d * w_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/ucdr_merge.sv]
`default_nettype none

`include "uint8_conv_dot_requant_unit_assert.svh"

module ucdr_merge import ucdr_pkg::*; #(
	parameter int ACC_BITS = ACC_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       accept,
	input  wire logic                       last,
	input  wire logic signed [31:0]         bias,
	input  wire logic signed [PROD_W-1:0]   prods [LANES],
	output logic                            start_s2,
	output logic signed [ACC_BITS-1:0]      final_s2,
	output logic signed [31:0]              bias_s2
);

	localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
	localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

	logic                        valid_s1;
	logic                        last_s1;
	logic signed [31:0]          bias_s1;
	logic signed [ACC_BITS-1:0]  acc_q;
	logic signed [LSUM_W-1:0]    lsum;
	logic signed [ACC_BITS:0]    wide;
	logic signed [ACC_BITS-1:0]  acc_next;

	always_comb begin
		lsum = '0;
		for (int i = 0; i < LANES; i++) begin
			lsum = lsum + LSUM_W'(prods[i]);
		end
	end

	assign wide = (ACC_BITS+1)'(acc_q) + (ACC_BITS+1)'(lsum);

	always_comb begin
		if (wide[ACC_BITS] != wide[ACC_BITS-1]) begin
			acc_next = wide[ACC_BITS] ? ACC_MIN : ACC_MAX;
		end else begin
			acc_next = wide[ACC_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			start_s2 <= 1'b0;
			acc_q    <= '0;
		end else begin
			valid_s1 <= accept;
			start_s2 <= valid_s1 && last_s1;
			if (accept) begin
				last_s1 <= last;
			end
			if (valid_s1) begin
				if (last_s1) begin
					acc_q <= '0;
				end else begin
					acc_q <= acc_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bias_s1 <= bias;
		end
		if (valid_s1 && last_s1) begin
			final_s2 <= acc_next;
			bias_s2  <= bias_s1;
		end
	end

	`UCDR_ASSERT_NEXT(a_acc_cleared, valid_s1 && last_s1, acc_q == '0 && start_s2,
		"accumulator not cleared after the closing transfer")
	`UCDR_ASSERT_NOW(a_start_alone, start_s2, !valid_s1,
		"new item entered while a result was being started")

endmodule

`default_nettype wire

[hw/rtl/ucdr_requant.sv]
`default_nettype none

`include "uint8_conv_dot_requant_unit_assert.svh"

module ucdr_requant import ucdr_pkg::*; #(
	parameter int ACC_BITS = ACC_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic signed [ACC_BITS-1:0] acc,
	input  wire logic signed [31:0]         bias,
	input  wire rq_cfg_t                    cfg,
	input  wire logic                       out_ready,
	output logic                            out_valid_q,
	output logic [7:0]                      out_value_q,
	output logic                            clipped_q,
	output logic                            done_q
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAG,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_SUM,
		ST_SHIFT,
		ST_EMIT
	} state_t;

	localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
	localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
	localparam logic signed [Q_W-1:0]      Q_TOP   = Q_W'(U8_MAX);

	state_t                      state_q;
	logic signed [ACC_BITS-1:0]  v_q;
	logic                        neg_q;
	logic [MAG_W-1:0]            mag_q;
	logic [PP_W-1:0]             pp_lo_q;
	logic [PP_W-1:0]             pp_hi_q;
	logic [WIDE_W-1:0]           wide_q;
	logic [CAP_W-1:0]            r_q;

	logic signed [ACC_BITS:0]    bsum;
	logic signed [ACC_BITS-1:0]  v_next;
	logic [ACC_BITS-1:0]         mag_n;
	logic [WIDE_W-1:0]           half;
	logic [WIDE_W-1:0]           shr;
	logic signed [Q_W-1:0]       oz_s;
	logic signed [Q_W-1:0]       top_s;
	logic signed [Q_W-1:0]       rs;
	logic signed [Q_W-1:0]       q1;
	logic signed [Q_W-1:0]       q2;
	logic signed [Q_W-1:0]       q3;
	logic [7:0]                  res;
	logic                        clip;
	logic                        emit;

	assign bsum = (ACC_BITS+1)'(acc) + (ACC_BITS+1)'(bias);

	always_comb begin
		if (bsum[ACC_BITS] != bsum[ACC_BITS-1]) begin
			v_next = bsum[ACC_BITS] ? ACC_MIN : ACC_MAX;
		end else begin
			v_next = bsum[ACC_BITS-1:0];
		end
	end

	assign mag_n = v_q[ACC_BITS-1] ? ACC_BITS'(-v_q) : ACC_BITS'(v_q);
	assign half  = (cfg.shift == '0) ? '0 : (WIDE_W'(1) << (cfg.shift - 1'b1));
	assign shr   = wide_q >> cfg.shift;

	assign oz_s  = Q_W'(cfg.out_zero);
	assign top_s = Q_W'(cfg.relu6_top);
	assign rs    = neg_q ? -Q_W'(r_q) : Q_W'(r_q);
	assign q1    = rs + oz_s;

	always_comb begin
		q2 = q1;
		if ((cfg.act_mode == ACT_RELU || cfg.act_mode == ACT_RELU6) && q1 < oz_s) begin
			q2 = oz_s;
		end
		q3 = q2;
		if (cfg.act_mode == ACT_RELU6 && q2 > top_s) begin
			q3 = top_s;
		end
		if (q3 < 0) begin
			res  = '0;
			clip = 1'b1;
		end else if (q3 > Q_TOP) begin
			res  = U8_MAX;
			clip = 1'b1;
		end else begin
			res  = q3[7:0];
			clip = 1'b0;
		end
	end

	assign emit = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			done_q      <= 1'b0;
			out_value_q <= '0;
			clipped_q   <= 1'b0;
			v_q         <= '0;
			neg_q       <= 1'b0;
			mag_q       <= '0;
			pp_lo_q     <= '0;
			pp_hi_q     <= '0;
			wide_q      <= '0;
			r_q         <= '0;
		end else begin
			done_q <= emit;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						v_q     <= v_next;
						state_q <= ST_MAG;
					end
				end
				ST_MAG: begin
					neg_q   <= v_q[ACC_BITS-1];
					mag_q   <= MAG_W'(mag_n);
					state_q <= ST_MUL_LO;
				end
				ST_MUL_LO: begin
					pp_lo_q <= PP_W'(mag_q[HALF_W-1:0]) * PP_W'(cfg.mult);
					state_q <= ST_MUL_HI;
				end
				ST_MUL_HI: begin
					pp_hi_q <= PP_W'(mag_q[MAG_W-1:HALF_W]) * PP_W'(cfg.mult);
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					wide_q  <= WIDE_W'(pp_lo_q) + (WIDE_W'(pp_hi_q) << HALF_W) + half;
					state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					r_q     <= (shr > WIDE_W'(CAP_VAL)) ? CAP_VAL : CAP_W'(shr);
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit) begin
						out_value_q <= res;
						clipped_q   <= clip;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`UCDR_ASSERT_NOW(a_start_idle, start, state_q == ST_IDLE,
		"start while the requantizer is busy")
	`UCDR_ASSERT_NOW(a_done_valid, done_q, out_valid_q,
		"completion without a result in the output register")
	`UCDR_ASSERT_NOW(a_valid_rise, $rose(out_valid_q), $past(state_q == ST_EMIT),
		"result appeared outside the emit step")

endmodule

`default_nettype wire

[sim/uint8_conv_dot_requant_checker.sv]
`timescale 1ns / 1ps

module uint8_conv_dot_requant_checker import ucdr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [7:0]            act_0,
	input  logic [7:0]            act_1,
	input  logic [7:0]            act_2,
	input  logic [7:0]            act_3,
	input  logic [7:0]            wgt_0,
	input  logic [7:0]            wgt_1,
	input  logic [7:0]            wgt_2,
	input  logic [7:0]            wgt_3,
	input  logic [LANES-1:0]      lane_live,
	input  logic signed [31:0]    bias,
	input  logic                  last,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [7:0]            out_value,
	input  logic                  clipped,
	output int                    mismatches,
	output int                    results_owed
);

	localparam longint ACC_TOP = (longint'(1) <<< (ACC_BITS_DEF - 1)) - 1;
	localparam longint ACC_BOTTOM = -ACC_TOP - 1;
	localparam logic [127:0] MAG_LIMIT = 128'd1 << 40;

	typedef struct packed {
		logic [7:0] value;
		logic       clipped;
	} pixel_t;

	logic [7:0]         in_zero_q;
	logic [7:0]         wgt_zero_q;
	logic [7:0]         out_zero_q;
	logic [MULT_W-1:0]  mult_q;
	logic [SHIFT_W-1:0] shift_q;
	logic [1:0]         act_mode_q;
	logic [7:0]         relu6_top_q;
	longint             window_sum;
	int                 pixel_idx;
	pixel_t             owed_pixels[$];

	function automatic longint add_saturated(input longint a, input longint b);
		longint s;
		s = a + b;
		if (s > ACC_TOP)
			s = ACC_TOP;
		if (s < ACC_BOTTOM)
			s = ACC_BOTTOM;
		return s;
	endfunction

	// Multiply by the Q31 mantissa, round half away from zero, cap the magnitude.
	function automatic longint scale_round(input longint v);
		logic         neg;
		logic [63:0]  mag;
		logic [127:0] prod;
		neg = v < 0;
		mag = neg ? 64'(-v) : 64'(v);
		prod = {64'd0, mag} * {97'd0, mult_q};
		if (shift_q != 0)
			prod = prod + (128'd1 << (shift_q - 1));
		prod = prod >> shift_q;
		if (prod > MAG_LIMIT)
			prod = MAG_LIMIT;
		return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
	endfunction

	function automatic pixel_t finish_pixel(input longint total);
		longint q;
		longint c;
		pixel_t px;
		q = scale_round(total) + longint'(out_zero_q);
		if (act_mode_q == ACT_RELU || act_mode_q == ACT_RELU6) begin
			if (q < longint'(out_zero_q))
				q = longint'(out_zero_q);
			if (act_mode_q == ACT_RELU6 && q > longint'(relu6_top_q))
				q = longint'(relu6_top_q);
		end
		c = q < 0 ? 0 : (q > longint'(U8_MAX) ? longint'(U8_MAX) : q);
		px.value = c[7:0];
		px.clipped = c != q;
		return px;
	endfunction

	always @(posedge clk or negedge arst_n) begin : predict
		logic [7:0] acts [LANES];
		logic [7:0] wgts [LANES];
		longint     lane_dot;
		pixel_t     got;
		pixel_t     want;
		if (!arst_n) begin
			in_zero_q = '0;
			wgt_zero_q = '0;
			out_zero_q = '0;
			mult_q = MULT_RST;
			shift_q = SHIFT_RST;
			act_mode_q = ACT_NONE;
			relu6_top_q = U8_MAX;
			window_sum = 0;
			pixel_idx = 0;
			owed_pixels.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_IN_ZERO:   in_zero_q = cfg_data[7:0];
					REG_WGT_ZERO:  wgt_zero_q = cfg_data[7:0];
					REG_OUT_ZERO:  out_zero_q = cfg_data[7:0];
					REG_MULT:      mult_q = cfg_data[MULT_W-1:0];
					REG_SHIFT:     shift_q = cfg_data[SHIFT_W-1:0];
					REG_ACT_MODE:  act_mode_q = cfg_data[1:0];
					REG_RELU6_TOP: relu6_top_q = cfg_data[7:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got.value = out_value;
				got.clipped = clipped;
				if (owed_pixels.size() == 0) begin
					if (mismatches < 10)
						$display("Result %0d arrived with nothing expected: value %0d clipped %0b",
							pixel_idx, got.value, got.clipped);
					mismatches++;
				end else begin
					want = owed_pixels.pop_front();
					if (want !== got) begin
						if (mismatches < 10)
							$display("Result %0d: expected %0d clipped %0b, got %0d clipped %0b",
								pixel_idx, want.value, want.clipped, got.value, got.clipped);
						mismatches++;
					end
				end
				pixel_idx++;
			end
			if (in_valid && in_ready) begin
				acts = '{act_0, act_1, act_2, act_3};
				wgts = '{wgt_0, wgt_1, wgt_2, wgt_3};
				lane_dot = 0;
				for (int i = 0; i < LANES; i++)
					if (lane_live[i])
						lane_dot += (longint'(acts[i]) - longint'(in_zero_q)) *
							(longint'(wgts[i]) - longint'(wgt_zero_q));
				window_sum = add_saturated(window_sum, lane_dot);
				if (last) begin
					owed_pixels.push_back(finish_pixel(add_saturated(window_sum, longint'(bias))));
					window_sum = 0;
				end
			end
		end
		results_owed = owed_pixels.size();
	end

endmodule

[sim/uint8_conv_dot_requant_unit_test.sv]
`timescale 1ns / 1ps

module uint8_conv_dot_requant_unit_test;
	import ucdr_pkg::*;

	localparam int PHASES = 16;
	localparam int FIXED_SETS = 5;
	localparam int TOTAL_ITEMS = 1500;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 12;
	localparam logic [1:0] ACT_SPARE = 2'd3;

	typedef struct packed {
		logic [LANES-1:0][7:0] act;
		logic [LANES-1:0][7:0] wgt;
		logic [LANES-1:0]      live;
		logic signed [31:0]    bias;
		logic                  last;
	} conv_item_t;

	typedef struct packed {
		logic [7:0]         in_zero;
		logic [7:0]         wgt_zero;
		logic [7:0]         out_zero;
		logic [MULT_W-1:0]  mult;
		logic [SHIFT_W-1:0] shift;
		logic [1:0]         act_mode;
		logic [7:0]         relu6_top;
	} reg_set_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [7:0]            act_0 = '0;
	logic [7:0]            act_1 = '0;
	logic [7:0]            act_2 = '0;
	logic [7:0]            act_3 = '0;
	logic [7:0]            wgt_0 = '0;
	logic [7:0]            wgt_1 = '0;
	logic [7:0]            wgt_2 = '0;
	logic [7:0]            wgt_3 = '0;
	logic [LANES-1:0]      lane_live = '0;
	logic signed [31:0]    bias = '0;
	logic                  last = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [7:0]            out_value;
	logic                  clipped;
	int                    mismatches;
	int                    results_owed;
	int                    idle_pct = 0;
	int                    stall_pct = 0;
	int                    quiet_cycles = 0;

	uint8_conv_dot_requant_unit i_dut (.*);

	uint8_conv_dot_requant_checker i_checker (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk)
		out_ready <= $urandom_range(0, 99) >= stall_pct;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
	endtask

	task automatic load_regs(input reg_set_t rs);
		write_reg(REG_IN_ZERO, CFG_DATA_W'(rs.in_zero));
		write_reg(REG_WGT_ZERO, CFG_DATA_W'(rs.wgt_zero));
		write_reg(REG_OUT_ZERO, CFG_DATA_W'(rs.out_zero));
		write_reg(REG_MULT, CFG_DATA_W'(rs.mult));
		write_reg(REG_SHIFT, CFG_DATA_W'(rs.shift));
		write_reg(REG_ACT_MODE, CFG_DATA_W'(rs.act_mode));
		write_reg(REG_RELU6_TOP, CFG_DATA_W'(rs.relu6_top));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every expected result has come and the datapath has drained.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (results_owed != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic send_item(input conv_item_t it);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		act_0 <= it.act[0];
		act_1 <= it.act[1];
		act_2 <= it.act[2];
		act_3 <= it.act[3];
		wgt_0 <= it.wgt[0];
		wgt_1 <= it.wgt[1];
		wgt_2 <= it.wgt[2];
		wgt_3 <= it.wgt[3];
		lane_live <= it.live;
		bias <= it.bias;
		last <= it.last;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	function automatic conv_item_t uniform_item(input logic [7:0] a, input logic [7:0] w,
			input logic [LANES-1:0] live, input logic signed [31:0] b, input logic is_last);
		conv_item_t it;
		for (int i = 0; i < LANES; i++) begin
			it.act[i] = a;
			it.wgt[i] = w;
		end
		it.live = live;
		it.bias = b;
		it.last = is_last;
		return it;
	endfunction

	function automatic logic [7:0] random_byte();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return 8'($urandom);
	endfunction

	function automatic conv_item_t random_item(input logic is_last);
		conv_item_t it;
		for (int i = 0; i < LANES; i++) begin
			it.act[i] = random_byte();
			it.wgt[i] = random_byte();
		end
		it.live = LANES'($urandom);
		if ($urandom_range(0, 3) == 0)
			it.bias = 32'($urandom);
		else
			it.bias = 32'(int'($urandom_range(0, 131072)) - 65536);
		it.last = is_last;
		return it;
	endfunction

	function automatic reg_set_t random_regs();
		reg_set_t rs;
		rs.in_zero = 8'($urandom);
		rs.wgt_zero = 8'($urandom);
		rs.out_zero = 8'($urandom);
		rs.mult = MULT_W'($urandom);
		if ($urandom_range(0, 7) == 0)
			rs.shift = SHIFT_W'($urandom_range(0, 62));
		else
			rs.shift = SHIFT_W'($urandom_range(36, 52));
		rs.act_mode = 2'($urandom_range(0, 3));
		rs.relu6_top = 8'($urandom);
		return rs;
	endfunction

	initial begin : stimulus
		reg_set_t fixed_sets [FIXED_SETS];
		int       sent;
		int       len;
		fixed_sets[0] = '{8'd255, 8'd255, 8'd0, 31'h7FFF_FFFF, 6'd0, ACT_NONE, 8'd255};
		fixed_sets[1] = '{8'd0, 8'd0, 8'd255, 31'd0, 6'd62, ACT_RELU, 8'd0};
		fixed_sets[2] = '{8'd128, 8'd128, 8'd128, 31'h4000_0000, 6'd40, ACT_RELU6, 8'd200};
		fixed_sets[3] = '{8'd17, 8'd200, 8'd100, 31'h5A5A_5A5A, 6'd38, ACT_RELU6, 8'd50};
		fixed_sets[4] = '{8'd3, 8'd250, 8'd60, 31'd12345678, 6'd30, ACT_SPARE, 8'd255};

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// Directed items under the register defaults: the result is half the sum, rounded, then clamped to 0..255.
		send_item(uniform_item(8'hFF, 8'hFF, 4'hF, 32'sd0, 1'b1));
		send_item(uniform_item(8'h00, 8'h00, 4'hF, 32'sd0, 1'b1));
		send_item(uniform_item(8'hFF, 8'hFF, 4'h0, 32'sd0, 1'b1));
		send_item(uniform_item(8'h00, 8'hFF, 4'h0, 32'h7FFF_FFFF, 1'b1));
		send_item(uniform_item(8'hFF, 8'h00, 4'h0, 32'h8000_0000, 1'b1));
		send_item(uniform_item(8'h00, 8'h00, 4'h0, 32'sd1, 1'b1));
		send_item(uniform_item(8'h00, 8'h00, 4'h0, -32'sd1, 1'b1));
		send_item(uniform_item(8'h00, 8'h00, 4'h0, 32'sd3, 1'b1));
		send_item(uniform_item(8'h00, 8'h00, 4'h0, -32'sd3, 1'b1));
		send_item(uniform_item(8'h00, 8'h00, 4'h0, 32'sd510, 1'b1));
		send_item(uniform_item(8'h00, 8'h00, 4'h0, 32'sd512, 1'b1));
		send_item(uniform_item(8'hAA, 8'h55, 4'h5, 32'sd0, 1'b0));
		send_item(uniform_item(8'h55, 8'hAA, 4'hA, 32'sd0, 1'b0));
		send_item(uniform_item(8'hFF, 8'h01, 4'h3, 32'sd0, 1'b0));
		send_item(uniform_item(8'h01, 8'hFF, 4'hC, -32'sd200, 1'b1));
		settle();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 63;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 63;
				end
				default: begin
					idle_pct = 26;
					stall_pct = 26;
				end
			endcase
			load_regs(ph < FIXED_SETS ? fixed_sets[ph] : random_regs());
			sent = 0;
			while (sent < TOTAL_ITEMS / PHASES) begin
				len = $urandom_range(1, 6);
				for (int k = 0; k < len; k++) begin
					send_item(random_item(k == len - 1));
					sent++;
				end
			end
			settle();
		end

		if (mismatches == 0 && results_owed == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
